// ===== rtl/csbp_pkg.sv =====
// ----------------------------------------------------------------------------
// Buffer pool frame table package
// Shared types, constants and request/result structs.
// ----------------------------------------------------------------------------
package csbp_pkg;

    localparam int SLOTS     = 1024;
    localparam int KEY_WIDTH = 32;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = SLOT_W + 1;
    localparam int USE_W     = 4;
    localparam int CFG_W     = 11;
    localparam int IDX_W     = 2;

    localparam logic [IDX_W-1:0] CFG_ACTIVE = 2'd0;
    localparam logic [IDX_W-1:0] CFG_CAP    = 2'd1;
    localparam logic [IDX_W-1:0] CFG_PASSES = 2'd2;

    localparam logic [1:0] K_LOOKUP  = 2'd0;
    localparam logic [1:0] K_INSERT  = 2'd1;
    localparam logic [1:0] K_RELEASE = 2'd2;
    localparam logic [1:0] K_TICK    = 2'd3;

    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_MISS     = 3'd1;
    localparam logic [2:0] ST_FREE     = 3'd2;
    localparam logic [2:0] ST_EVICT    = 3'd3;
    localparam logic [2:0] ST_REJECT   = 3'd4;
    localparam logic [2:0] ST_RELEASED = 3'd5;
    localparam logic [2:0] ST_SWEPT    = 3'd6;

    typedef struct packed {
        logic [1:0]           kind;
        logic [KEY_WIDTH-1:0] key;
    } t_req;

    typedef struct packed {
        logic [2:0]           status;
        logic [9:0]           slot;
        logic                 evicted_valid;
        logic [KEY_WIDTH-1:0] evicted_key;
    } t_res;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_SCAN_WAIT, S_DECIDE,
        S_WALK, S_WALK_WAIT, S_WRITE, S_DONE
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic clr_step;
        logic load_req;
        logic scan_start;
        logic scan_step;
        logic walk_start;
        logic walk_step;
        logic do_write;
        logic emit;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic clr_last;
        logic scan_last;
        logic walk_last;
        logic walk_found;
        logic is_tick;
        logic is_insert_miss;
        logic has_free;
        logic passes_zero;
    } t_sts;

endpackage

// ===== rtl/csbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Frame table controller
// Sequences clearing, the linear key/free scan, the clock walk and writeback.
// ----------------------------------------------------------------------------
module csbp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  csbp_pkg::t_sts  i_sts,
    output csbp_pkg::t_cmd  o_cmd
);

    csbp_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csbp_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            csbp_pkg::S_CLEAR:     if (i_sts.clr_last) n_state = csbp_pkg::S_IDLE;
            csbp_pkg::S_IDLE:      if (i_start) n_state = csbp_pkg::S_SCAN;
            csbp_pkg::S_SCAN:      n_state = csbp_pkg::S_SCAN_WAIT;
            csbp_pkg::S_SCAN_WAIT: begin
                if (i_sts.scan_last) n_state = csbp_pkg::S_DECIDE;
            end
            csbp_pkg::S_DECIDE: begin
                if (i_sts.is_tick) begin
                    n_state = csbp_pkg::S_WALK;
                end else if (i_sts.is_insert_miss && !i_sts.has_free &&
                             !i_sts.passes_zero) begin
                    n_state = csbp_pkg::S_WALK;
                end else begin
                    n_state = csbp_pkg::S_WRITE;
                end
            end
            csbp_pkg::S_WALK:      n_state = csbp_pkg::S_WALK_WAIT;
            csbp_pkg::S_WALK_WAIT: begin
                if (i_sts.walk_found || i_sts.walk_last) n_state = csbp_pkg::S_WRITE;
            end
            csbp_pkg::S_WRITE:     n_state = csbp_pkg::S_DONE;
            csbp_pkg::S_DONE:      n_state = csbp_pkg::S_IDLE;
            default:               n_state = csbp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_busy = 1'b1;
        case (r_state)
            csbp_pkg::S_CLEAR:     o_cmd.clr_step = 1'b1;
            csbp_pkg::S_IDLE: begin
                o_busy = 1'b0;
                o_cmd.load_req = i_start;
            end
            csbp_pkg::S_SCAN:      o_cmd.scan_start = 1'b1;
            csbp_pkg::S_SCAN_WAIT: o_cmd.scan_step = 1'b1;
            csbp_pkg::S_WALK:      o_cmd.walk_start = 1'b1;
            csbp_pkg::S_WALK_WAIT: o_cmd.walk_step = 1'b1;
            csbp_pkg::S_WRITE:     o_cmd.do_write = 1'b1;
            csbp_pkg::S_DONE:      o_cmd.emit = 1'b1;
            default:               o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/csbp_dp.sv =====
// ----------------------------------------------------------------------------
// Frame table datapath
// Frame memories, scan and walk pointers, and the result register.
// ----------------------------------------------------------------------------
module csbp_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  csbp_pkg::t_req                     i_req,
    input  csbp_pkg::t_cmd                     i_cmd,
    input  logic [csbp_pkg::CNT_W-1:0]         i_live,
    input  logic [csbp_pkg::USE_W-1:0]         i_cap,
    input  logic [csbp_pkg::USE_W-1:0]         i_passes,
    output csbp_pkg::t_sts                     o_sts,
    output logic                               o_valid,
    output csbp_pkg::t_res                     o_res
);

    localparam int SW = csbp_pkg::SLOT_W;
    localparam int CW = csbp_pkg::CNT_W;
    localparam int UW = csbp_pkg::USE_W;
    localparam int KW = csbp_pkg::KEY_WIDTH;
    // Per-frame metadata word: occupied, pinned, usage.
    localparam int MW = UW + 2;

    logic [KW-1:0] r_key_mem [csbp_pkg::SLOTS];
    logic [MW-1:0] r_meta_mem[csbp_pkg::SLOTS];

    // One read port each, one write port shared.
    logic [SW-1:0] rd_addr;
    logic [KW-1:0] r_rd_key;
    logic [MW-1:0] r_rd_meta;
    logic          wr_en, kwr_en;
    logic [SW-1:0] wr_addr;
    logic [MW-1:0] wr_meta;

    csbp_pkg::t_req r_req;

    always_ff @(posedge i_clk) begin
        if (kwr_en) r_key_mem[wr_addr] <= r_req.key;
        r_rd_key <= r_key_mem[rd_addr];
    end

    // A read of the frame being written returns the new word, which a
    // one-frame walk needs on its next revolution.
    always_ff @(posedge i_clk) begin
        if (wr_en) r_meta_mem[wr_addr] <= wr_meta;
        r_rd_meta <= (wr_en && wr_addr == rd_addr) ? wr_meta : r_meta_mem[rd_addr];
    end

    logic [CW-1:0]  r_clr;
    logic [SW-1:0]  r_ptr;       // address issued this cycle
    logic [SW-1:0]  r_prev;      // address whose data is in the read registers
    logic           r_rd_vld;
    logic           n_rd_vld;
    logic [CW-1:0]  r_left;      // reads still to issue
    logic           r_match, r_free;
    logic [SW-1:0]  r_match_idx, r_free_idx;
    logic [SW-1:0]  r_hand;
    logic [UW-1:0]  r_pass;
    logic [CW-1:0]  r_steps;     // remaining steps in this revolution
    logic           r_found;
    logic [SW-1:0]  r_found_idx;
    logic [KW-1:0]  r_ev_key;
    logic [MW-1:0]  r_match_meta;
    logic           r_is_tick;
    logic           r_valid;
    csbp_pkg::t_res r_res;
    csbp_pkg::t_res n_res;

    logic [SW-1:0] live_m1;
    assign live_m1 = SW'(i_live - CW'(1));

    logic       rd_occ, rd_pin;
    logic [UW-1:0] rd_use;
    assign rd_occ = r_rd_meta[MW-1];
    assign rd_pin = r_rd_meta[MW-2];
    assign rd_use = r_rd_meta[UW-1:0];

    logic [SW-1:0] hand_base, hand_next;
    assign hand_base = ({1'b0, r_hand} >= i_live) ? '0 : r_hand;
    assign hand_next = (r_ptr == live_m1) ? '0 : SW'(r_ptr + SW'(1));

    // Walk data for r_prev is valid while r_rd_vld; writes to it happen
    // in the same cycle so the next read of a different frame sees fresh data.
    logic walk_dec, walk_hit;
    assign walk_hit = r_rd_vld && rd_occ && !rd_pin && (rd_use == '0) && !r_is_tick;
    assign walk_dec = r_rd_vld && rd_occ && !rd_pin && (rd_use != '0);

    logic is_insert;
    assign is_insert = (r_req.kind == csbp_pkg::K_INSERT);

    assign n_rd_vld = i_cmd.scan_start || i_cmd.walk_start ||
                      (i_cmd.scan_step && (r_left != '0)) ||
                      (i_cmd.walk_step && !r_found && !walk_hit &&
                       ((r_steps != '0) || (!r_is_tick && r_pass != i_passes)));

    always_comb begin
        rd_addr = r_ptr;
        if (i_cmd.scan_start) begin
            rd_addr = '0;
        end else if (i_cmd.walk_start) begin
            rd_addr = hand_base;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        kwr_en  = 1'b0;
        wr_addr = r_prev;
        wr_meta = '0;
        if (i_cmd.clr_step) begin
            wr_en   = 1'b1;
            wr_addr = SW'(r_clr);
        end else if (i_cmd.walk_step && walk_dec && !r_found) begin
            wr_en   = 1'b1;
            wr_meta = {rd_occ, rd_pin, UW'(rd_use - UW'(1))};
        end else if (i_cmd.do_write) begin
            if (r_match && r_req.kind != csbp_pkg::K_TICK) begin
                wr_addr = r_match_idx;
                if (r_req.kind == csbp_pkg::K_RELEASE) begin
                    wr_en   = 1'b1;
                    wr_meta = {2'b10, r_match_meta[UW-1:0]};
                end else begin
                    wr_en   = 1'b1;
                    wr_meta = {2'b11, (r_match_meta[UW-1:0] < i_cap) ?
                               UW'(r_match_meta[UW-1:0] + UW'(1)) :
                               r_match_meta[UW-1:0]};
                end
            end else if (is_insert && (r_free || r_found)) begin
                wr_en   = 1'b1;
                kwr_en  = 1'b1;
                wr_addr = r_free ? r_free_idx : r_found_idx;
                wr_meta = {2'b11, UW'(1)};
            end
        end
    end

    always_comb begin
        n_res = '0;
        if (r_is_tick) begin
            n_res.status = csbp_pkg::ST_SWEPT;
        end else if (r_match) begin
            n_res.slot   = 10'(r_match_idx);
            n_res.status = (r_req.kind == csbp_pkg::K_RELEASE) ?
                           csbp_pkg::ST_RELEASED : csbp_pkg::ST_HIT;
        end else if (is_insert && r_free) begin
            n_res.status = csbp_pkg::ST_FREE;
            n_res.slot   = 10'(r_free_idx);
        end else if (is_insert && r_found) begin
            n_res.status        = csbp_pkg::ST_EVICT;
            n_res.slot          = 10'(r_found_idx);
            n_res.evicted_valid = 1'b1;
            n_res.evicted_key   = r_ev_key;
        end else if (is_insert) begin
            n_res.status = csbp_pkg::ST_REJECT;
        end else begin
            n_res.status = csbp_pkg::ST_MISS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_hand  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.clr_step) r_clr <= CW'(r_clr + CW'(1));
            if (i_cmd.walk_start) r_hand <= hand_base;
            if (i_cmd.walk_step && r_rd_vld && !r_found && !walk_hit) begin
                r_hand <= (r_prev == live_m1) ? '0 : SW'(r_prev + SW'(1));
            end
            if (i_cmd.walk_step && walk_hit && !r_found) begin
                r_hand <= (r_prev == live_m1) ? '0 : SW'(r_prev + SW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_vld <= n_rd_vld;
        if (i_cmd.load_req) begin
            r_req <= i_req;
        end
        if (i_cmd.scan_start) begin
            r_ptr    <= SW'(1);
            r_prev   <= '0;
            r_left   <= CW'(i_live - CW'(1));
            r_match  <= 1'b0;
            r_free   <= 1'b0;
            r_found  <= 1'b0;
            r_is_tick <= (r_req.kind == csbp_pkg::K_TICK);
            r_pass   <= '0;
        end
        if (i_cmd.scan_step) begin
            if (r_rd_vld) begin
                if (rd_occ && r_rd_key == r_req.key && !r_match) begin
                    r_match      <= 1'b1;
                    r_match_idx  <= r_prev;
                    r_match_meta <= r_rd_meta;
                end
                if (!rd_occ && !r_free) begin
                    r_free     <= 1'b1;
                    r_free_idx <= r_prev;
                end
            end
            if (r_left != '0) begin
                r_prev   <= r_ptr;
                r_ptr    <= SW'(r_ptr + SW'(1));
                r_left   <= CW'(r_left - CW'(1));
            end
        end
        if (i_cmd.walk_start) begin
            r_ptr    <= (hand_base == live_m1) ? '0 : SW'(hand_base + SW'(1));
            r_prev   <= hand_base;
            r_steps  <= CW'(i_live - CW'(1));
            r_pass   <= UW'(1);
        end
        if (i_cmd.walk_step && !r_found) begin
            if (walk_hit) begin
                r_found     <= 1'b1;
                r_found_idx <= r_prev;
                r_ev_key    <= r_rd_key;
            end else if (r_steps != '0) begin
                r_prev   <= r_ptr;
                r_ptr    <= hand_next;
                r_steps  <= CW'(r_steps - CW'(1));
            end else if (!r_is_tick && r_pass != i_passes) begin
                r_prev   <= r_ptr;
                r_ptr    <= hand_next;
                r_steps  <= CW'(i_live - CW'(1));
                r_pass   <= UW'(r_pass + UW'(1));
            end
        end
        if (i_cmd.do_write) begin
            r_res <= n_res;
        end
    end

    assign o_sts.clr_last       = (r_clr == CW'(csbp_pkg::SLOTS - 1));
    assign o_sts.scan_last      = (r_left == '0) && !r_rd_vld;
    assign o_sts.walk_last      = r_rd_vld && !walk_hit && (r_steps == '0) &&
                                  (r_is_tick || r_pass == i_passes);
    assign o_sts.walk_found     = walk_hit;
    assign o_sts.is_tick        = r_is_tick;
    assign o_sts.is_insert_miss = is_insert && !r_match;
    assign o_sts.has_free       = r_free;
    assign o_sts.passes_zero    = (i_passes == '0);

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== rtl/clock_sweep_buffer_pool.sv =====
// ----------------------------------------------------------------------------
// Buffer pool frame table with clock-sweep replacement
// Lookup, insert and release scan the active frames; an eviction adds a clock
// walk of up to max_passes revolutions, and a tick adds a single revolution.
// One request at a time; one frame memory read per cycle sets the rate.
// After reset a clearing pass over all 1024 frames runs with busy high.
// The result strobe lasts one cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
module clock_sweep_buffer_pool (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  csbp_pkg::t_req                    i_req,
    output logic                              o_res_valid,
    output csbp_pkg::t_res                    o_res,
    input  logic                              i_cfg_we,
    input  logic [csbp_pkg::IDX_W-1:0]        i_cfg_idx,
    input  logic [csbp_pkg::CFG_W-1:0]        i_cfg_data
);

    logic [csbp_pkg::CFG_W-1:0] r_active;
    logic [csbp_pkg::USE_W-1:0] r_cap, r_passes;
    logic [csbp_pkg::CNT_W-1:0] live;
    csbp_pkg::t_cmd cmd;
    csbp_pkg::t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= csbp_pkg::CFG_W'(1024);
            r_cap    <= csbp_pkg::USE_W'(5);
            r_passes <= csbp_pkg::USE_W'(5);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                csbp_pkg::CFG_ACTIVE: r_active <= i_cfg_data;
                csbp_pkg::CFG_CAP:    r_cap    <= i_cfg_data[csbp_pkg::USE_W-1:0];
                csbp_pkg::CFG_PASSES: r_passes <= i_cfg_data[csbp_pkg::USE_W-1:0];
                default: ;
            endcase
        end
    end

    // Zero acts as one frame, anything above the table size as the full table.
    always_comb begin
        if (r_active == '0) begin
            live = csbp_pkg::CNT_W'(1);
        end else if (r_active > csbp_pkg::CFG_W'(csbp_pkg::SLOTS)) begin
            live = csbp_pkg::CNT_W'(csbp_pkg::SLOTS);
        end else begin
            live = csbp_pkg::CNT_W'(r_active);
        end
    end

    csbp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    csbp_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .i_live   (live),
        .i_cap    (r_cap),
        .i_passes (r_passes),
        .o_sts    (sts),
        .o_valid  (o_res_valid),
        .o_res    (o_res)
    );

endmodule
